[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[hw/rtl/whp_pkg.sv]
package whp_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PAYLOAD  = 3'd1,
        ST_NOT_RIFF = 3'd2,
        ST_NOT_WAVE = 3'd3,
        ST_FMT_ID   = 3'd4,
        ST_FMT_SIZE = 3'd5,
        ST_NON_PCM  = 3'd6,
        ST_NO_DATA  = 3'd7
    } status_t;

    localparam int unsigned POS_W   = 6;
    localparam logic [POS_W-1:0] HDR_LEN = POS_W'(44);

    // Header positions grouped by four bytes.
    typedef logic [3:0] grp_t;
    localparam grp_t GRP_RIFF   = 4'd0;
    localparam grp_t GRP_WAVE   = 4'd2;
    localparam grp_t GRP_FMT    = 4'd3;
    localparam grp_t GRP_SIZE   = 4'd4;
    localparam grp_t GRP_FORMAT = 4'd5;
    localparam grp_t GRP_RATE   = 4'd6;
    localparam grp_t GRP_BITS   = 4'd8;
    localparam grp_t GRP_DATA   = 4'd9;

    localparam logic [1:0] OFS_FORMAT_LO = 2'd0;
    localparam logic [1:0] OFS_FORMAT_HI = 2'd1;
    localparam logic [1:0] OFS_CHANNELS  = 2'd2;
    localparam logic [1:0] OFS_BITS      = 2'd2;
    localparam logic [1:0] OFS_FIRST     = 2'd0;
    localparam logic [1:0] OFS_LAST      = 2'd3;

    function automatic logic is_err(status_t s);
        return s >= ST_NOT_RIFF;
    endfunction

    // Byte expected at each checked header position.
    function automatic logic [7:0] hdr_expect(logic [POS_W-1:0] pos);
        logic [7:0] e;
        e = 8'h00;
        case (pos)
            6'd0, 6'd39:  e = 8'h52 ^ ((pos == 6'd39) ? 8'h33 : 8'h00);
            6'd1:         e = 8'h49;
            6'd2, 6'd3:   e = 8'h46;
            6'd8:         e = 8'h57;
            6'd9, 6'd37:  e = 8'h61 ^ ((pos == 6'd9) ? 8'h20 : 8'h00);
            6'd10:        e = 8'h56;
            6'd11:        e = 8'h45;
            6'd12:        e = 8'h66;
            6'd13:        e = 8'h6D;
            6'd14, 6'd38: e = 8'h74;
            6'd15:        e = 8'h20;
            6'd16:        e = 8'h10;
            6'd20:        e = 8'h01;
            6'd36:        e = 8'h64;
            default:      e = 8'h00;
        endcase
        return e;
    endfunction

endpackage

[hw/rtl/wave_header_parser_top.sv]
// RIFF/WAVE PCM header parser. Feed the file one byte per beat on s_, with
// s_restart set on the first byte of each file. Every input beat yields one
// result beat: status 0 while a good header byte is seen, 1 with the byte on
// m_payload_byte once the 44-byte header has passed, or a sticky error code
// (2 not RIFF .. 7 no data) from the first bad byte until the next restart.
// The result is registered and is out in the cycle after the input beat;
// one byte per cycle is sustained while m_ready is high, the check being a
// position-keyed compare before a single result register refilled on drain.
module wave_header_parser_top
    import whp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_payload_byte,
    output logic        m_header_valid,
    output logic [31:0] m_rate_hz,
    output logic [7:0]  m_sample_bits,
    output logic [7:0]  m_channel_count
);

    logic [POS_W-1:0] pos_reg, pos_next, pos_c;
    status_t          st_reg, st_next, st_c;
    logic             flag_reg, flag_next, flag_c;
    logic [31:0]      rate_reg, rate_next, rate_c;
    logic [7:0]       bits_reg, bits_next, bits_c;
    logic [7:0]       chan_reg, chan_next, chan_c;
    status_t          status_reg, status_next, err_c;
    logic [7:0]       pay_reg, pay_next;
    logic             valid_reg, valid_next;
    logic             accept, match;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_c  = s_restart ? '0 : pos_reg;
        st_c   = s_restart ? ST_OK : st_reg;
        flag_c = s_restart ? 1'b0 : flag_reg;
        rate_c = s_restart ? '0 : rate_reg;
        bits_c = s_restart ? '0 : bits_reg;
        chan_c = s_restart ? '0 : chan_reg;

        pos_next    = pos_c;
        st_next     = st_c;
        flag_next   = flag_c;
        rate_next   = rate_c;
        bits_next   = bits_c;
        chan_next   = chan_c;
        pay_next    = 8'h00;
        err_c       = ST_OK;
        status_next = ST_OK;
        match       = (s_data_byte == hdr_expect(pos_c));

        if (is_err(st_c)) begin
            status_next = st_c;
        end else if (pos_c >= HDR_LEN) begin
            pos_next    = HDR_LEN;
            st_next     = ST_PAYLOAD;
            status_next = ST_PAYLOAD;
            pay_next    = s_data_byte;
        end else begin
            unique case (pos_c[5:2])
                GRP_RIFF: if (!match) err_c = ST_NOT_RIFF;
                GRP_WAVE: if (!match) err_c = ST_NOT_WAVE;
                GRP_FMT:  if (!match) err_c = ST_FMT_ID;
                GRP_DATA: if (!match) err_c = ST_NO_DATA;
                GRP_SIZE: begin
                    // fmt size must read 16: track a running match over four bytes
                    flag_next = (pos_c[1:0] == OFS_FIRST) ? match : (flag_c && match);
                    if (pos_c[1:0] == OFS_LAST && !flag_next) err_c = ST_FMT_SIZE;
                end
                GRP_FORMAT: begin
                    case (pos_c[1:0])
                        OFS_FORMAT_LO: flag_next = match;
                        OFS_FORMAT_HI: if (!(flag_c && match)) err_c = ST_NON_PCM;
                        OFS_CHANNELS:  chan_next = s_data_byte;
                        default: ;
                    endcase
                end
                GRP_RATE: rate_next[{pos_c[1:0], 3'b000} +: 8] = s_data_byte;
                GRP_BITS: if (pos_c[1:0] == OFS_BITS) bits_next = s_data_byte;
                default: ;
            endcase

            if (err_c != ST_OK) begin
                st_next     = err_c;
                status_next = err_c;
            end else begin
                pos_next = pos_c + POS_W'(1);
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            st_reg     <= ST_OK;
            flag_reg   <= 1'b0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            chan_reg   <= '0;
            valid_reg  <= 1'b0;
            status_reg <= ST_OK;
            pay_reg    <= '0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                pos_reg    <= pos_next;
                st_reg     <= st_next;
                flag_reg   <= flag_next;
                rate_reg   <= rate_next;
                bits_reg   <= bits_next;
                chan_reg   <= chan_next;
                status_reg <= status_next;
                pay_reg    <= pay_next;
            end
        end
    end

    // Parse state is only updated with the result, so it doubles as output.
    assign m_valid         = valid_reg;
    assign m_status        = status_reg;
    assign m_payload_byte  = pay_reg;
    assign m_header_valid  = !is_err(st_reg) && (pos_reg >= HDR_LEN);
    assign m_rate_hz       = rate_reg;
    assign m_sample_bits   = bits_reg;
    assign m_channel_count = chan_reg;

endmodule

[hw/rtl/whp_checker.sv]
`include "assert_macros.svh"

module whp_checker
    import whp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [7:0]  m_payload_byte,
    input logic        m_header_valid
);

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_payload_byte))
    `ASSERT_IMPL(a_pay_zero, aclk, aresetn, m_valid && (m_status != ST_PAYLOAD), m_payload_byte == 8'h00)
    `ASSERT_IMPL(a_pay_hdr, aclk, aresetn, m_valid && (m_status == ST_PAYLOAD), m_header_valid)
    `ASSERT_IMPL(a_hdr_noerr, aclk, aresetn, m_valid && m_header_valid, (m_status == ST_PAYLOAD) || (m_status == ST_OK))

endmodule

bind wave_header_parser_top whp_checker u_whp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_payload_byte (m_payload_byte),
    .m_header_valid (m_header_valid)
);
